// ----- rtl/pfec_pkg.sv -----
// pfec_pkg: shared operation and status codes and the result struct
// for the pipe fifo with end counts; no dependencies
`default_nettype none

package pfec_pkg;

  // operation codes of an input transaction
  localparam logic [2:0] OP_READ         = 3'd0;
  localparam logic [2:0] OP_WRITE        = 3'd1;
  localparam logic [2:0] OP_OPEN_READER  = 3'd2;
  localparam logic [2:0] OP_OPEN_WRITER  = 3'd3;
  localparam logic [2:0] OP_CLOSE_READER = 3'd4;
  localparam logic [2:0] OP_CLOSE_WRITER = 3'd5;

  // status codes of a result transaction
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_WOULD_BLOCK     = 3'd1;
  localparam logic [2:0] ST_END_OF_STREAM   = 3'd2;
  localparam logic [2:0] ST_BROKEN_PIPE     = 3'd3;
  localparam logic [2:0] ST_COUNT_SATURATED = 3'd4;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;

  // per-operation result flags handed from control to output stage
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               rd_hit;
    logic               all_closed;
    logic               req_end;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/pfec_mem.sv -----
// pfec_mem: byte store of the pipe, one write port and one read port
// with registered read data; depends on pfec_pkg
`default_nettype none

module pfec_mem #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AddrW-1:0]          waddr_i,
  input  wire logic [pfec_pkg::ByteW-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AddrW-1:0]          raddr_i,
  output logic      [pfec_pkg::ByteW-1:0] rdata_o
);

  logic [pfec_pkg::ByteW-1:0] mem_q [Depth];
  logic [pfec_pkg::ByteW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/pfec_ctrl.sv -----
// pfec_ctrl: ring pointers, fill level and end counts; decodes one
// operation per transaction and drives the byte store; depends on pfec_pkg
`default_nettype none

module pfec_ctrl #(
  parameter int unsigned BUFFER_DEPTH  = 64,
  parameter int unsigned END_COUNT_MAX = 15,
  localparam int unsigned PtrW  = $clog2(BUFFER_DEPTH),
  localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned CntW  = $clog2(END_COUNT_MAX + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [pfec_pkg::OpW-1:0]    op_i,
  input  wire logic [pfec_pkg::ByteW-1:0]  wdata_i,
  input  wire logic                        eor_i,
  output logic                             mem_we_o,
  output logic      [PtrW-1:0]             mem_waddr_o,
  output logic      [pfec_pkg::ByteW-1:0]  mem_wdata_o,
  output logic                             mem_re_o,
  output logic      [PtrW-1:0]             mem_raddr_o,
  output pfec_pkg::res_t                   res_o,
  output logic      [FillW-1:0]            fill_o
);

  logic [PtrW-1:0]  rptr_q, rptr_d, wptr_q, wptr_d;
  logic [FillW-1:0] held_q, held_d;
  logic [CntW-1:0]  readers_q, readers_d, writers_q, writers_d;
  logic [pfec_pkg::StatusW-1:0] status;
  logic             rd_hit, wr_hit;
  pfec_pkg::res_t   res_q;
  logic [FillW-1:0] fill_q;

  // operation decode and next state
  always_comb begin
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    held_d    = held_q;
    readers_d = readers_q;
    writers_d = writers_q;
    status    = pfec_pkg::ST_OK;
    rd_hit    = 1'b0;
    wr_hit    = 1'b0;
    case (op_i)
      pfec_pkg::OP_READ: begin
        if (held_q == '0) begin
          status = (writers_q != '0) ? pfec_pkg::ST_WOULD_BLOCK
                                     : pfec_pkg::ST_END_OF_STREAM;
        end else begin
          rd_hit = 1'b1;
          rptr_d = (rptr_q == PtrW'(BUFFER_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
          held_d = held_q - 1'b1;
        end
      end
      pfec_pkg::OP_WRITE: begin
        if (readers_q == '0) begin
          status = pfec_pkg::ST_BROKEN_PIPE;
        end else if (held_q == FillW'(BUFFER_DEPTH)) begin
          status = pfec_pkg::ST_WOULD_BLOCK;
        end else begin
          wr_hit = 1'b1;
          wptr_d = (wptr_q == PtrW'(BUFFER_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
          held_d = held_q + 1'b1;
        end
      end
      pfec_pkg::OP_OPEN_READER: begin
        if (readers_q >= CntW'(END_COUNT_MAX)) begin
          status = pfec_pkg::ST_COUNT_SATURATED;
        end else begin
          readers_d = readers_q + 1'b1;
        end
      end
      pfec_pkg::OP_OPEN_WRITER: begin
        if (writers_q >= CntW'(END_COUNT_MAX)) begin
          status = pfec_pkg::ST_COUNT_SATURATED;
        end else begin
          writers_d = writers_q + 1'b1;
        end
      end
      pfec_pkg::OP_CLOSE_READER: begin
        if (readers_q != '0) begin
          readers_d = readers_q - 1'b1;
        end
      end
      pfec_pkg::OP_CLOSE_WRITER: begin
        if (writers_q != '0) begin
          writers_d = writers_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // pointer and count state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q    <= '0;
      wptr_q    <= '0;
      held_q    <= '0;
      readers_q <= CntW'(1);
      writers_q <= CntW'(1);
    end else if (accept_i) begin
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      held_q    <= held_d;
      readers_q <= readers_d;
      writers_q <= writers_d;
    end
  end

  // result fields of the transaction just taken
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q.status     <= status;
      res_q.rd_hit     <= rd_hit;
      res_q.all_closed <= (readers_d == '0) && (writers_d == '0);
      res_q.req_end    <= eor_i;
      fill_q           <= held_d;
    end
  end

  // byte store access; a read only reaches entries written at an earlier edge
  assign mem_we_o    = accept_i && wr_hit;
  assign mem_waddr_o = wptr_q;
  assign mem_wdata_o = wdata_i;
  assign mem_re_o    = accept_i && rd_hit;
  assign mem_raddr_o = rptr_q;
  assign res_o       = res_q;
  assign fill_o      = fill_q;

endmodule

`default_nettype wire

// ----- rtl/pipe_fifo_with_end_counts_core.sv -----
// pipe_fifo_with_end_counts_core: byte pipe with reader and writer end counts
// a result passes the pending stage, then the output register, before it is offered
// throughput: one transaction per cycle while the output side takes results;
//   set by the output register, which frees in every cycle its result is taken
// reset: pointers and fill level clear, both end counts become one,
//   the byte store is not cleared; depends on pfec_pkg, pfec_ctrl, pfec_mem
`default_nettype none

module pipe_fifo_with_end_counts_core #(
  parameter int unsigned BUFFER_DEPTH  = 64,
  parameter int unsigned END_COUNT_MAX = 15,
  localparam int unsigned PtrW   = $clog2(BUFFER_DEPTH),
  localparam int unsigned FillW  = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned OutW   = pfec_pkg::StatusW + pfec_pkg::ByteW + FillW + 1,
  localparam int unsigned OutPadW = ((OutW + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // s_axis_tdata_i: operation [2:0], write_data [10:3], zero pad
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [15:0]        s_axis_tdata_i,
  input  wire logic               s_axis_tlast_i,  // end_of_request
  // m_axis_tdata_o: status, read_data, fill_level, all_ends_closed, zero pad
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [OutPadW-1:0]      m_axis_tdata_o,
  output logic                    m_axis_tlast_o   // request_end
);

  logic                       accept;
  logic                       out_free;
  logic                       pend_valid_q;
  logic                       out_valid_q;
  logic                       mem_we, mem_re;
  logic [PtrW-1:0]            mem_waddr, mem_raddr;
  logic [pfec_pkg::ByteW-1:0] mem_wdata, mem_rdata;
  pfec_pkg::res_t             res;
  logic [FillW-1:0]           fill;
  logic [OutW-1:0]            out_data_q;
  logic                       out_last_q;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  pfec_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .END_COUNT_MAX(END_COUNT_MAX)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (s_axis_tdata_i[2:0]),
    .wdata_i    (s_axis_tdata_i[10:3]),
    .eor_i      (s_axis_tlast_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .res_o      (res),
    .fill_o     (fill)
  );

  pfec_mem #(
    .Depth(BUFFER_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // pending stage waits on the store read; it moves on whenever output is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_free) begin
        pend_valid_q <= accept;
        out_valid_q  <= pend_valid_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_free && pend_valid_q) begin
      out_data_q <= {res.all_closed, fill,
                     (res.rd_hit ? mem_rdata : pfec_pkg::ByteW'(0)), res.status};
      out_last_q <= res.req_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutPadW'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  // an accepted transaction always lands in the pending stage
  a_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_valid_q)
    else $error("accepted transaction not pending");

  // a pending result is never dropped while the output is stalled
  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !out_free |=> pend_valid_q)
    else $error("pending result lost under stall");

  // a pending result that may advance shows up at the output
  a_pending_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && out_free |=> m_axis_tvalid_o)
    else $error("pending result did not reach output");

endmodule

`default_nettype wire
